// ===== rtl/tpf_pkg.sv =====
`default_nettype none

package tpf_pkg;

  // Default queue depth
  localparam int unsigned DepthDefault = 16;

  // Threshold after reset
  localparam logic signed [31:0] ThreshReset = 32'sd59;

  // Register byte addresses
  localparam logic [1:0] ADDR_THRESH = 2'd0;

  // Operation codes
  localparam logic [1:0] OP_PLAIN    = 2'd0;
  localparam logic [1:0] OP_PRIORITY = 2'd1;
  localparam logic [1:0] OP_DEQUEUE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One command item
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic signed [31:0] head_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } rsp_t;

  // Shared control broadcast to every cell
  typedef struct packed {
    logic               enq;       // insert value this cycle
    logic               deq;       // shift toward head this cycle
    logic               prio_hit;  // priority enqueue of a value above threshold
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tpf_cell.sv =====
`default_nettype none

module tpf_cell
  import tpf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic signed [31:0] thresh_i,
  input  wire logic               valid_i,     // this slot holds an entry
  input  wire logic signed [31:0] left_val_i,  // neighbor toward head
  input  wire logic signed [31:0] right_val_i, // neighbor toward tail
  input  wire logic               ins_ahead_i, // insertion point lies toward head
  output logic                    ins_ahead_o,
  output logic signed [31:0]      val_o
);

  logic signed [31:0] val_q, val_d;
  logic               above, stop;

  // Insertion stops at the first empty slot, or for a priority hit at the
  // first entry that is not above the threshold.
  assign above       = val_q > thresh_i;
  assign stop        = !valid_i || (ctrl_i.prio_hit && !above);
  assign ins_ahead_o = ins_ahead_i || stop;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.deq) begin
      val_d = right_val_i;
    end else if (ctrl_i.enq) begin
      if (ins_ahead_i) begin
        val_d = left_val_i;
      end else if (stop) begin
        val_d = ctrl_i.value;
      end
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// ===== rtl/threshold_priority_fifo_core.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------
// command   | start / busy           | cmd_i  (op, value)
// result    | done_o strobe          | result_o (head_value, status, occupancy)
// config    | APB psel/penable/pready| pwdata/prdata, threshold at addr 0
//
// Each command is decoded and placed combinationally: all cells compare against the
// threshold at once and the insertion point ripples down the cell chain.
// The result appears on done_o/result_o the cycle after start; busy stays low.
// Reset (rst_ni, async low) empties the queue and loads threshold 59.
// The receiver cannot stall; each result is valid for exactly one cycle.
`default_nettype none

module threshold_priority_fifo_core
  import tpf_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd_i,
  output logic             done_o,
  output rsp_t             result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]    count_q, count_d;
  logic signed [31:0] thresh_q;
  logic               done_q;
  rsp_t               rsp_q, rsp_d;
  logic               accept, is_enq, is_deq, full, empty;
  cell_ctrl_t         ctrl;

  logic signed [31:0] cell_val  [DEPTH];
  logic               ins_ahead [DEPTH+1];

  // Configuration port, single register
  assign pready = 1'b1;
  assign prdata = thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_THRESH)) begin
      thresh_q <= pwdata;
    end
  end

  // Command decode
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign is_enq = (cmd_i.op == OP_PLAIN) || (cmd_i.op == OP_PRIORITY);
  assign is_deq = (cmd_i.op == OP_DEQUEUE);

  always_comb begin
    ctrl.enq      = accept && is_enq && !full;
    ctrl.deq      = accept && is_deq && !empty;
    ctrl.prio_hit = (cmd_i.op == OP_PRIORITY) && (cmd_i.value > thresh_q);
    ctrl.value    = cmd_i.value;
  end

  // Cell chain, head at index 0
  assign ins_ahead[0] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [31:0] left_val, right_val;
    if (k == 0) begin : g_head
      assign left_val = cmd_i.value;
    end else begin : g_mid
      assign left_val = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_body
      assign right_val = cell_val[k+1];
    end

    tpf_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .thresh_i    (thresh_q),
      .valid_i     (CntW'(k) < count_q),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .ins_ahead_i (ins_ahead[k]),
      .ins_ahead_o (ins_ahead[k+1]),
      .val_o       (cell_val[k])
    );
  end

  // Count and result
  always_comb begin
    count_d         = count_q;
    rsp_d.head_value = '0;
    rsp_d.status    = ST_OK;
    if (ctrl.enq) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.deq) begin
      count_d          = count_q - 1'b1;
      rsp_d.head_value = cell_val[0];
    end
    if (is_enq && full) begin
      rsp_d.status = ST_FULL;
    end else if (is_deq && empty) begin
      rsp_d.status = ST_EMPTY;
    end
    rsp_d.occupancy = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/tpf_checker.sv =====
`default_nettype none

module tpf_checker
  import tpf_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t cmd_i,
  input wire logic done_o,
  input wire rsp_t result_o
);

  // One result per accepted command, in the cycle after it
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (done_o == $past(start && !busy)))
    else $error("result strobe does not follow command");

  // Empty dequeue reports nothing held and zero data
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |->
      (result_o.occupancy == 5'd0 && result_o.head_value == '0))
    else $error("empty status with nonzero occupancy or data");

  // Dropped enqueue only when full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_FULL) |->
      (result_o.occupancy == 5'(DEPTH) && result_o.head_value == '0))
    else $error("full status while not full");

  // Successful dequeue lowers occupancy by one relative to previous result
  a_deq_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && $past(start && !busy) &&
     $past(cmd_i.op) == OP_DEQUEUE && result_o.status == ST_OK) |->
      (result_o.occupancy == 5'($past(result_o.occupancy) - 5'd1)))
    else $error("dequeue did not lower occupancy");

endmodule

bind threshold_priority_fifo_core tpf_checker #(.DEPTH(DEPTH)) u_tpf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpf_pkg::*;

  localparam int unsigned QDepth = DepthDefault;
  localparam int DrainCycles = 3;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic signed [31:0] WordMin = 32'sh8000_0000;
  localparam logic signed [31:0] WordMax = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic done_o;
  rsp_t result_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Shadow of the queue contents and the threshold register
  logic signed [31:0] queue_words[$];
  logic signed [31:0] model_thresh;
  rsp_t pending_results[$];
  int unsigned error_count = 0;
  bit no_gaps = 1'b0;

  threshold_priority_fifo_core #(
    .DEPTH(QDepth)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Applies one command to the shadow queue and returns the result it gives
  function automatic rsp_t apply_queue_op(cmd_t c);
    rsp_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_DEQUEUE: begin
        if (queue_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_value = queue_words.pop_front();
        end
      end
      OP_PLAIN, OP_PRIORITY: begin
        if (queue_words.size() >= QDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = queue_words.size();
          // above-threshold word goes after the leading run of such words
          if (c.op == OP_PRIORITY && queue_words.size() > 0 && c.value > model_thresh) begin
            pos = 0;
            while (pos < queue_words.size() && queue_words[pos] > model_thresh) pos++;
          end
          queue_words.insert(pos, c.value);
        end
      end
      default: ;
    endcase
    r.occupancy = 5'(queue_words.size());
    return r;
  endfunction

  // Sends one item after a gap, random unless no_gaps; returns right after the accepting edge
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] value);
    cmd_t c;
    int unsigned gap;
    c.op = op;
    c.value = value;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    pending_results.push_back(apply_queue_op(c));
  endtask

  // Holds off the sender until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit is_write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ADDR_THRESH;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    rdata = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write the threshold while idle, then read it back
  task automatic set_threshold(input logic signed [31:0] thresh);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, thresh, rd);
    model_thresh = thresh;
    @(posedge clk_i);
    apb_access(1'b0, '0, rd);
    if (rd !== thresh) begin
      $display("%0t: threshold readback expected %0d got %0d", $time, thresh, $signed(rd));
      error_count++;
    end
  endtask

  // Mostly words close to the threshold so placement is exercised
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    longint v;
    sel = $urandom_range(0, 3);
    if (sel == 0) return $urandom;
    if (sel == 1) return model_thresh + $urandom_range(0, 1);
    v = longint'(model_thresh) + longint'($urandom_range(0, 40)) - 20;
    if (v > longint'(WordMax)) v = longint'(WordMax);
    if (v < longint'(WordMin)) v = longint'(WordMin);
    return v[31:0];
  endfunction

  function automatic logic [1:0] pick_op(input int unsigned enq_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OpUnused;
    if (r < 3 + enq_pct) return ($urandom_range(0, 99) < 55) ? OP_PRIORITY : OP_PLAIN;
    return OP_DEQUEUE;
  endfunction

  // Bursts with varying enqueue bias so the queue swings between empty and full
  task automatic run_traffic(input int unsigned n);
    int unsigned enq_pct;
    enq_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 90;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      send_cmd(pick_op(enq_pct), pick_value());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_empty_and_unused_op();
    send_cmd(OP_DEQUEUE, 32'hdead_beef);
    send_cmd(OpUnused, 32'h1234_5678);
    // priority word into an empty queue
    send_cmd(OP_PRIORITY, 32'd100);
  endtask

  task automatic test_priority_placement();
    send_cmd(OP_PLAIN, WordMin);
    send_cmd(OP_PLAIN, WordMax);
    send_cmd(OP_PRIORITY, 32'd60);
    send_cmd(OP_PRIORITY, 32'd59);
    send_cmd(OP_PLAIN, 32'hffff_ffff);
    send_cmd(OP_PRIORITY, WordMax);
    send_cmd(OpUnused, 32'h0);
    send_cmd(OP_DEQUEUE, 32'h0);
    send_cmd(OP_DEQUEUE, 32'h0);
  endtask

  task automatic test_full_queue();
    while (queue_words.size() < QDepth) begin
      send_cmd(($urandom_range(0, 1) != 0) ? OP_PRIORITY : OP_PLAIN, pick_value());
    end
    send_cmd(OP_PLAIN, 32'd1);
    send_cmd(OP_PRIORITY, WordMax);
    drain_results();
  endtask

  task automatic test_threshold_register();
    set_threshold(WordMin);
    run_traffic(150);
    set_threshold(WordMax);
    run_traffic(150);
    set_threshold(32'sd0);
    run_traffic(150);
    set_threshold($urandom);
    run_traffic(150);
  endtask

  task automatic test_random_traffic();
    set_threshold(ThreshReset);
    run_traffic(1300);
  endtask

  // Result checker: each strobed result against the oldest expectation
  always @(negedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result head %0d status %0d occupancy %0d", $time,
                 result_o.head_value, result_o.status, result_o.occupancy);
        error_count++;
      end else begin
        exp_rsp = pending_results.pop_front();
        if (result_o.head_value !== exp_rsp.head_value) begin
          $display("%0t: head_value expected %0d got %0d", $time,
                   exp_rsp.head_value, result_o.head_value);
          error_count++;
        end
        if (result_o.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_rsp.status,
                   result_o.status);
          error_count++;
        end
        if (result_o.occupancy !== exp_rsp.occupancy) begin
          $display("%0t: occupancy expected %0d got %0d", $time, exp_rsp.occupancy,
                   result_o.occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    model_thresh = ThreshReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused_op();
    test_priority_placement();
    test_full_queue();
    test_threshold_register();
    test_random_traffic();
    drain_results();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tpf_pkg.sv
rtl/tpf_cell.sv
rtl/threshold_priority_fifo_core.sv
rtl/tpf_checker.sv
sim/tb.sv
